### rtl/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared types, mode codes and the saturation helper of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam logic [3:0] MODE_ADD      = 4'd0;
  localparam logic [3:0] MODE_SUB      = 4'd1;
  localparam logic [3:0] MODE_MUL      = 4'd2;
  localparam logic [3:0] MODE_DIV      = 4'd3;
  localparam logic [3:0] MODE_MIN      = 4'd4;
  localparam logic [3:0] MODE_MAX      = 4'd5;
  localparam logic [3:0] MODE_INC      = 4'd6;
  localparam logic [3:0] MODE_DEC      = 4'd7;
  localparam logic [3:0] MODE_TO_INT   = 4'd8;
  localparam logic [3:0] MODE_FROM_INT = 4'd9;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               a_greater;
    logic               a_less;
    logic               a_equal;
    logic               overflow;
    logic               div_zero;
  } out_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  // Side-band fields that travel alongside the divider
  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] res;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        ovf;
    logic        dz;
    logic        neg;
  } side_t;

  // Apply sign to a magnitude and clamp to the 32-bit signed range
  function automatic sat_t sat_signed(logic [64:0] q, logic neg);
    sat_t s;
    logic [64:0] negq;
    negq = 65'd0 - q;
    s.ovf = 1'b0;
    if (neg) begin
      if (q > 65'h0_8000_0000) begin
        s.ovf = 1'b1;
        s.res = 32'h8000_0000;
      end else begin
        s.res = negq[31:0];
      end
    end else begin
      if (q > 65'h0_7FFF_FFFF) begin
        s.ovf = 1'b1;
        s.res = 32'h7FFF_FFFF;
      end else begin
        s.res = q[31:0];
      end
    end
    return s;
  endfunction

endpackage

### rtl/fpalu_mul.sv
// ----------------------------------------------------------------------------
// fpalu_mul
// Two-stage magnitude multiplier with round-half-away and saturation.
// ----------------------------------------------------------------------------
module fpalu_mul import fpalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  input  logic        neg,
  output logic [31:0] res,
  output logic        ovf
);

  localparam logic [64:0] HALF = 65'd1 << (FRAC_BITS - 1);

  logic [63:0] prod_r;
  logic        neg_r;
  logic [31:0] res_r;
  logic        ovf_r;
  logic [64:0] rnd;
  sat_t        sat_nxt;

  always_comb begin
    rnd     = ({1'b0, prod_r} + HALF) >> FRAC_BITS;
    sat_nxt = sat_signed(rnd, neg_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= mag_a * mag_b;
    neg_r  <= neg;
    res_r  <= sat_nxt.res;
    ovf_r  <= sat_nxt.ovf;
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

### rtl/fpalu_div.sv
// ----------------------------------------------------------------------------
// fpalu_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpalu_div import fpalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic [31:0]             mag_a,
  input  logic [31:0]             mag_b,
  output logic [32+FRAC_BITS-1:0] quot,
  output logic [31:0]             rem,
  output logic [31:0]             den
);

  localparam int NUM_W = 32 + FRAC_BITS;

  logic [32:0]      rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [NUM_W-1:0] q_r   [NUM_W];
  logic [31:0]      den_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [32:0]      rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] q_in;
    logic [31:0]      den_in;
    logic [32:0]      rem_sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = 33'd0;
      assign num_in = {mag_a, {FRAC_BITS{1'b0}}};
      assign q_in   = '0;
      assign den_in = mag_b;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign rem_sh = {rem_in[31:0], num_in[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_sh - {1'b0, den_in} : rem_sh;
      num_r[k] <= {num_in[NUM_W-2:0], 1'b0};
      q_r[k]   <= {q_in[NUM_W-2:0], ge};
      den_r[k] <= den_in;
    end
  end

  assign quot = q_r[NUM_W-1];
  assign rem  = rem_r[NUM_W-1][31:0];
  assign den  = den_r[NUM_W-1];

endmodule

### rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point ALU: add, sub, mul, div, min, max, inc, dec,
// to/from integer, with compare, overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
//  channel | ports                    | beat taken when
//  --------+--------------------------+-----------------------------
//  input   | start, busy, in_data     | start high, busy low
//  result  | out_valid, out_data      | every cycle out_valid is high
//
//  One beat may enter every cycle; busy is held low.
//  Pipe length (Q24.8 by default) is set by the divider:
//  one input stage, 32 + FRAC_BITS quotient stages, one rounding stage.
//  Every mode takes the same path length, so results leave in order.
//  rst_n (synchronous) clears the valid bits only; data registers float.
//  The receiver cannot stall, so nothing in the pipe ever holds.
// ----------------------------------------------------------------------------
module fixed_point_alu import fpalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int NUM_W  = 32 + FRAC_BITS;
  localparam int LINE_N = NUM_W - 1;   // side line depth to match the divider

  // Stage 1: registered operands
  logic        s1_vld_r;
  logic [3:0]  s1_mode_r;
  logic [31:0] s1_a_r;
  logic [31:0] s1_b_r;
  logic [31:0] s1_mag_a_r;
  logic [31:0] s1_mag_b_r;
  logic        s1_neg_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r  <= in_data.mode;
    s1_a_r     <= in_data.operand_a;
    s1_b_r     <= in_data.operand_b;
    s1_mag_a_r <= in_data.operand_a[31] ? 32'd0 - in_data.operand_a : in_data.operand_a;
    s1_mag_b_r <= in_data.operand_b[31] ? 32'd0 - in_data.operand_b : in_data.operand_b;
    s1_neg_r   <= in_data.operand_a[31] ^ in_data.operand_b[31];
  end

  // Stage 2: simple ops and flags
  side_t s2_nxt;
  side_t s2_r;
  logic  s2_vld_r;

  always_comb begin
    s2_nxt      = '0;
    s2_nxt.mode = s1_mode_r;
    s2_nxt.gt   = $signed(s1_a_r) > $signed(s1_b_r);
    s2_nxt.lt   = $signed(s1_a_r) < $signed(s1_b_r);
    s2_nxt.eq   = s1_a_r == s1_b_r;
    s2_nxt.neg  = s1_neg_r;
    s2_nxt.dz   = (s1_mode_r == MODE_DIV) && (s1_b_r == 32'd0);
    unique case (s1_mode_r)
      MODE_ADD:      s2_nxt.res = s1_a_r + s1_b_r;
      MODE_SUB:      s2_nxt.res = s1_a_r - s1_b_r;
      MODE_MIN:      s2_nxt.res = s2_nxt.lt ? s1_a_r : s1_b_r;
      MODE_MAX:      s2_nxt.res = s2_nxt.gt ? s1_a_r : s1_b_r;
      MODE_INC:      s2_nxt.res = s1_a_r + 32'd1;
      MODE_DEC:      s2_nxt.res = s1_a_r - 32'd1;
      MODE_TO_INT:   s2_nxt.res = 32'($signed(s1_a_r) >>> FRAC_BITS);
      MODE_FROM_INT: s2_nxt.res = s1_a_r << FRAC_BITS;
      default:       s2_nxt.res = 32'd0;  // mul/div filled later, spare codes zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  // Multiplier: result registered through prod_r and res_r after stage 1
  logic [31:0] mul_res;
  logic        mul_ovf;

  fpalu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .mag_a (s1_mag_a_r),
    .mag_b (s1_mag_b_r),
    .neg   (s1_neg_r),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  // Divider: quotient registered through its quotient stages after stage 1
  logic [NUM_W-1:0] div_quot;
  logic [31:0]      div_rem;
  logic [31:0]      div_den;

  fpalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .mag_a (s1_mag_a_r),
    .mag_b (s1_mag_b_r),
    .quot  (div_quot),
    .rem   (div_rem),
    .den   (div_den)
  );

  // Side line; the multiply result joins at its second tap
  side_t line_r   [LINE_N];
  logic  line_vld_r [LINE_N];

  for (genvar j = 0; j < LINE_N; j++) begin : g_line
    side_t src;
    logic  src_vld;
    side_t nxt;

    if (j == 0) begin : g_head
      assign src     = s2_r;
      assign src_vld = s2_vld_r;
    end else begin : g_tail
      assign src     = line_r[j-1];
      assign src_vld = line_vld_r[j-1];
    end

    always_comb begin
      nxt = src;
      if (j == 1 && src.mode == MODE_MUL) begin
        nxt.res = mul_res;
        nxt.ovf = mul_ovf;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        line_vld_r[j] <= 1'b0;
      end else begin
        line_vld_r[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      line_r[j] <= nxt;
    end
  end

  // Output stage: round the quotient (half away), saturate, select
  side_t       tail;
  logic        rnd_up;
  logic [64:0] div_q;
  sat_t        div_sat;
  out_t        out_nxt;
  logic        out_valid_r;
  out_t        out_data_r;

  assign tail = line_r[LINE_N-1];

  always_comb begin
    rnd_up  = {div_rem, 1'b0} >= {1'b0, div_den};
    div_q   = 65'(div_quot) + 65'(rnd_up);
    div_sat = sat_signed(div_q, tail.neg);

    out_nxt.a_greater = tail.gt;
    out_nxt.a_less    = tail.lt;
    out_nxt.a_equal   = tail.eq;
    out_nxt.div_zero  = tail.dz;
    out_nxt.result    = tail.res;
    out_nxt.overflow  = tail.ovf;
    if (tail.mode == MODE_DIV && !tail.dz) begin
      out_nxt.result   = div_sat.res;
      out_nxt.overflow = div_sat.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= line_vld_r[LINE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/fpalu_chk.sv
// ----------------------------------------------------------------------------
// fpalu_chk
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpalu_chk import fpalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  localparam int LAT = 34 + FRAC_BITS;

  // Every accepted beat comes out after the fixed latency
  a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat did not appear at the output");

  a_lat_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_valid)
    else $error("result beat without an accepted input");

  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.a_greater, out_data.a_less, out_data.a_equal}))
    else $error("compare flags not one-hot");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_zero) |-> (out_data.result == 32'sd0 && !out_data.overflow))
    else $error("divide by zero gave a non-zero result or overflow");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      (out_data.result == 32'sh7FFF_FFFF || out_data.result == 32'sh8000_0000))
    else $error("overflow without a saturated result");

endmodule

bind fixed_point_alu fpalu_chk #(.FRAC_BITS(FRAC_BITS)) u_fpalu_chk (.*);

### tb/alu_checker.sv
// ----------------------------------------------------------------------------
// alu_checker
// Watches the operand and result channels of the fixed-point ALU, works out
// each expected result from the operands and compares field by field.
// ----------------------------------------------------------------------------
module alu_checker import fpalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  out_t awaited_q[$];

  // Sign applied to a magnitude, clamped to 32 bits
  function automatic void clamp(input logic [63:0] q, input logic neg,
                                output logic [31:0] r, output logic ov);
    ov = 1'b0;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        ov = 1'b1;
        r = 32'h8000_0000;
      end else begin
        r = 32'(64'd0 - q);
      end
    end else if (q > 64'h7FFF_FFFF) begin
      ov = 1'b1;
      r = 32'h7FFF_FFFF;
    end else begin
      r = q[31:0];
    end
  endfunction

  function automatic out_t alu_result(input in_t b);
    out_t o;
    logic signed [31:0] sa, sb;
    logic [63:0] ma, mb, q, num, den;
    logic neg;
    sa = b.operand_a;
    sb = b.operand_b;
    ma = sa[31] ? 64'(-64'(sa)) : 64'(sa);
    mb = sb[31] ? 64'(-64'(sb)) : 64'(sb);
    neg = sa[31] != sb[31];
    o = '0;
    case (b.mode)
      MODE_ADD:  o.result = sa + sb;
      MODE_SUB:  o.result = sa - sb;
      MODE_MUL: begin
        q = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        clamp(q, neg, o.result, o.overflow);
      end
      MODE_DIV: begin
        if (sb == 0) begin
          o.div_zero = 1'b1;
        end else begin
          num = ma << FRAC_BITS;
          den = mb;
          q = (2 * num + den) / (2 * den);
          clamp(q, neg, o.result, o.overflow);
        end
      end
      MODE_MIN:      o.result = (sa < sb) ? sa : sb;
      MODE_MAX:      o.result = (sa > sb) ? sa : sb;
      MODE_INC:      o.result = sa + 1;
      MODE_DEC:      o.result = sa - 1;
      MODE_TO_INT:   o.result = sa >>> FRAC_BITS;
      MODE_FROM_INT: o.result = sa << FRAC_BITS;
      default:       o.result = '0;
    endcase
    o.a_greater = sa > sb;
    o.a_less    = sa < sb;
    o.a_equal   = sa == sb;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      awaited_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (start && !busy) awaited_q.push_back(alu_result(in_data));
      if (out_valid) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_q.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected res=%h gt=%b lt=%b eq=%b ov=%b dz=%b",
                     $time, want.result, want.a_greater, want.a_less, want.a_equal,
                     want.overflow, want.div_zero);
            $display("%0t:          actual   res=%h gt=%b lt=%b eq=%b ov=%b dz=%b",
                     $time, out_data.result, out_data.a_greater, out_data.a_less,
                     out_data.a_equal, out_data.overflow, out_data.div_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= awaited_q.size();
    end
  end
endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operand beats into the fixed-point ALU; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import fpalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 34 + FRAC;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending;

  always #5 clk = ~clk;

  fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data
  );

  alu_checker #(.FRAC_BITS(FRAC)) u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .fail_count, .pending
  );

  // Operand picker: biased toward the edges and small values, where the
  // rounding, saturation and sign cases sit.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 2) - 1;
      3: return 32'($signed($urandom_range(0, 8191)) - 4096);
      4: return 32'($signed($urandom_range(0, 32'h1FFFF)) - 32'h10000);
      default: return $urandom();
    endcase
  endfunction

  // Put one beat on the pins at the falling edge and hold until it is taken.
  // start stays high between back-to-back beats.
  task automatic send_beat(input logic [3:0] m, input logic [31:0] a,
                           input logic [31:0] b);
    in_data <= '{mode: m, operand_a: a, operand_b: b};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic random_gap(input bit quiet);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  initial begin
    logic [3:0]  m;
    logic [31:0] a, b;
    int timer;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every mode at the extremes, plus the named special cases
    send_beat(MODE_ADD,      32'h7FFF_FFFF, 32'h0000_0001);   // wrap
    send_beat(MODE_SUB,      32'h8000_0000, 32'h0000_0001);   // wrap
    send_beat(MODE_MUL,      32'h7FFF_FFFF, 32'h7FFF_FFFF);   // positive saturation
    send_beat(MODE_MUL,      32'h8000_0000, 32'h7FFF_FFFF);   // negative saturation
    send_beat(MODE_MUL,      32'h0000_0080, 32'h0000_0001);   // half rounds away
    send_beat(MODE_MUL,      32'hFFFF_FF80, 32'h0000_0001);   // negative half
    send_beat(MODE_MUL,      32'h8000_0000, 32'h0000_0100);   // exactly -2^31
    send_beat(MODE_DIV,      32'h0000_0100, 32'h0000_0000);   // divide by zero
    send_beat(MODE_DIV,      32'h8000_0000, 32'h0000_0001);   // saturates
    send_beat(MODE_DIV,      32'h0000_0001, 32'h0000_0200);   // half rounds away
    send_beat(MODE_DIV,      32'hFFFF_FFFF, 32'h0000_0200);
    send_beat(MODE_DIV,      32'h8000_0000, 32'h8000_0000);
    send_beat(MODE_MIN,      32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(MODE_MAX,      32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(MODE_MIN,      32'h0000_0005, 32'h0000_0005);
    send_beat(MODE_INC,      32'h7FFF_FFFF, 32'h0000_0000);
    send_beat(MODE_DEC,      32'h8000_0000, 32'hFFFF_FFFF);
    send_beat(MODE_TO_INT,   32'hFFFF_FF01, 32'h0000_0000);   // rounds down
    send_beat(MODE_TO_INT,   32'h7FFF_FFFF, 32'h0000_0000);
    send_beat(MODE_FROM_INT, 32'h00FF_FFFF, 32'h0000_0000);
    send_beat(MODE_FROM_INT, 32'h8000_0001, 32'h0000_0000);   // wraps
    send_beat(4'd10, 32'h0000_0001, 32'h0000_0002);           // unused codes
    send_beat(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random beats; the last stretch runs with no gaps
    for (int i = 0; i < 1530; i++) begin
      m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, 9));
      a = pick_operand();
      case ($urandom_range(0, 5))
        0: b = a;
        1: b = '0;
        default: b = pick_operand();
      endcase
      send_beat(m, a, b);
      random_gap(i > 1300);
    end
    start <= 1'b0;

    timer = 0;
    while (pending != 0 && timer < 10000) begin
      @(negedge clk);
      timer++;
    end
    repeat (LATENCY + 10) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (~1550 beats, longest gaps)
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### files.f
rtl/fpalu_pkg.sv
rtl/fpalu_mul.sv
rtl/fpalu_div.sv
rtl/fixed_point_alu.sv
rtl/fpalu_chk.sv
tb/alu_checker.sv
tb/testbench.sv
